// File: design/kde_pkg.sv
// kde_pkg: shared constants, types and the gaussian table for the kernel density evaluator
// depends on nothing; imported by every kde module
`timescale 1ns / 1ps
`default_nettype none
package kde_pkg;
    localparam int MAX_SAMPLES       = 1024;
    localparam int MIN_SAMPLES       = 30;
    localparam int GAUSS_TABLE_DEPTH = 512;
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int GIDX_W  = $clog2(GAUSS_TABLE_DEPTH);
    localparam int SUM_W   = 24 + CNT_W;
    localparam logic [23:0] EPA_Q24 = 24'd5627249;
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic REG_KERNEL_TYPE  = 1'b0;
    localparam logic REG_INV_BW       = 1'b1;
    localparam logic KERNEL_GAUSS = 1'b0;

    // quotient by shift and subtract, evaluated at elaboration only
    function automatic logic [63:0] udiv_small(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-u), u unsigned Q.32, result Q.32, evaluated at elaboration only
    function automatic logic [63:0] neg_exp_q32(input logic [63:0] u);
        logic [63:0] whole, frac, term, e;
        logic signed [64:0] acc;
        whole = u >> 32;
        frac  = u & 64'hFFFF_FFFF;
        acc   = 65'sd4294967296;
        term  = 64'd4294967296;
        for (int k = 1; k <= 14; k++) begin
            term = (term * frac) >> 32;
            term = udiv_small(term, 64'(k));
            if ((k & 1) == 1) acc = acc - $signed({1'b0, term});
            else              acc = acc + $signed({1'b0, term});
        end
        e = acc[63:0];
        for (int k = 0; k < 40; k++) begin
            if (64'(k) < whole) e = (e * 64'd1580030169) >> 32;
        end
        return e;
    endfunction

    // table depth is a power of two, so the division by depth squared is a shift
    function automatic logic [23:0] gauss_entry(input logic [GIDX_W-1:0] i);
        logic [63:0] m, u, e, p;
        m = 64'(i) * 2 + 1;
        u = ((64'd8 * m * m) << 32) >> (2 * GIDX_W);
        e = neg_exp_q32(u);
        p = (64'd6693141 * e + 64'h8000_0000) >> 32;
        return p[23:0];
    endfunction

    typedef logic [23:0] t_gtab [GAUSS_TABLE_DEPTH];
    function automatic t_gtab build_gauss();
        t_gtab t;
        for (int i = 0; i < GAUSS_TABLE_DEPTH; i++) t[i] = gauss_entry(GIDX_W'(i));
        return t;
    endfunction
    localparam t_gtab GAUSS_TABLE = build_gauss();

    // sweep control from the sequencer to the term pipe
    typedef struct packed {
        logic        valid;
        logic        kernel;
        logic [31:0] point;
        logic [31:0] inv_bw;
    } t_term_ctl;
endpackage
`default_nettype wire

// File: design/kernel_density_evaluator.sv
// kernel_density_evaluator: top level, sample memory, sweep sequencer, output register
// depends on kde_pkg, kde_term, kde_scale
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  contents
// s_axis    in         tdata[1:0] mode, tdata[33:2] value (40 bits)
// m_axis    out        tdata[31:0] density, tuser status
// cfg       in         index 0 kernel_type, 1 inv_bandwidth
// an append or clear updates the count; a query with n samples passes through n memory
// reads, the term pipe stages and the sum register, the scaler start, the multiply,
// 67 bit-serial divide steps and the output register
// a short query (too few samples) answers the cycle after acceptance; reset clears the
// state, count, valid flags and configuration, not the memory; the output register holds
// a result until taken and no input transaction is taken while it is full
module kernel_density_evaluator import kde_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // mode[1:0], value[33:2], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // density[31:0]
    output logic             m_axis_tuser,   // status
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001, ST_SWEEP = 4'b0010, ST_DRAIN = 4'b0100, ST_DIV = 4'b1000
    } t_state;
    t_state r_state;
    logic r_kernel;
    logic [31:0] r_inv_bw, r_point;
    logic [CNT_W-1:0] r_count, r_idx;
    logic [31:0] r_mem [MAX_SAMPLES];
    logic [31:0] r_rd;
    logic r_rd_v;
    logic [SUM_W-1:0] r_sum;
    logic r_out_v, r_out_st;
    logic [31:0] r_out_d;
    logic w_acc, w_done, w_tv, w_start;
    logic [23:0] w_term;
    logic [31:0] w_dens;
    logic [1:0] w_mode;
    t_term_ctl w_ctl;

    assign o_cfg_ready = 1'b1;
    assign w_mode = s_axis_tdata[1:0];
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_v;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= 1'b0;
            r_inv_bw <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KERNEL_TYPE: r_kernel <= i_cfg_data[0];
                REG_INV_BW:      r_inv_bw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample memory: append writes, sweep reads
    always_ff @(posedge i_clk) begin
        if (w_acc && w_mode == MODE_APPEND && r_count < CNT_W'(MAX_SAMPLES))
            r_mem[r_count[ADDR_W-1:0]] <= s_axis_tdata[33:2];
        r_rd <= r_mem[r_idx[ADDR_W-1:0]];
    end

    assign w_ctl = '{valid: r_rd_v, kernel: r_kernel, point: r_point, inv_bw: r_inv_bw};
    kde_term u_term (.i_clk, .i_rst_n, .i_ctl(w_ctl), .i_sample(r_rd),
                     .o_valid(w_tv), .o_term(w_term));
    assign w_start = (r_state == ST_DRAIN) && !w_tv && !r_rd_v;
    kde_scale u_scale (.i_clk, .i_rst_n, .i_start(w_start), .i_sum(r_sum),
                       .i_inv_bw(r_inv_bw), .i_count(r_count),
                       .o_done(w_done), .o_density(w_dens));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            r_rd_v <= 1'b0;
            if (w_tv) r_sum <= r_sum + SUM_W'(w_term);
            unique case (r_state)
                ST_IDLE: if (w_acc) begin
                    case (w_mode)
                        MODE_APPEND: if (r_count < CNT_W'(MAX_SAMPLES))
                            r_count <= r_count + 1'b1;
                        MODE_CLEAR: r_count <= '0;
                        MODE_QUERY: if (r_count < CNT_W'(MIN_SAMPLES)) begin
                            r_out_v <= 1'b1; r_out_st <= 1'b1; r_out_d <= '0;
                        end else begin
                            r_point <= s_axis_tdata[33:2];
                            r_idx <= '0; r_sum <= '0;
                            r_state <= ST_SWEEP;
                        end
                        default: ;
                    endcase
                end
                ST_SWEEP: begin
                    r_rd_v <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_count - 1'b1) r_state <= ST_DRAIN;
                end
                ST_DRAIN: if (w_start) r_state <= ST_DIV;
                ST_DIV: if (w_done) begin
                    r_out_v <= 1'b1; r_out_st <= 1'b0; r_out_d <= w_dens;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tuser  = r_out_st;
endmodule
`default_nettype wire

// File: design/kde_term.sv
// kde_term: pipelined kernel term, from sample and point to a Q0.24 term
// depends on kde_pkg (gaussian table, control struct)
`timescale 1ns / 1ps
`default_nettype none
module kde_term import kde_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_term_ctl   i_ctl,
    input  wire logic [31:0] i_sample,
    output logic             o_valid,
    output logic [23:0]      o_term
);
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_k1, r_k2, r_k3, r_k4;
    logic [32:0] r_ad;
    logic [31:0] r_bw;
    logic [47:0] r_az;
    logic [34:0] r_lim;
    logic [23:0] r_term;
    logic [23:0] r_gterm;
    logic [26:0] r_hi;

    // stage 1: absolute difference
    logic signed [32:0] w_d;
    assign w_d = $signed({i_ctl.point[31], i_ctl.point}) - $signed({i_sample[31], i_sample});
    always_ff @(posedge i_clk) begin
        r_ad <= w_d[32] ? 33'(-w_d) : 33'(w_d);
        r_bw <= i_ctl.inv_bw;
        r_k1 <= i_ctl.kernel;
    end

    // stage 2: scale by inverse bandwidth (33x32)
    logic [64:0] w_p;
    assign w_p = 65'(r_ad) * 65'(r_bw);
    always_ff @(posedge i_clk) begin
        r_az <= w_p[63:16];
        r_k2 <= r_k1;
    end

    // stage 3: square for epanechnikov or table lookup
    logic [35:0] w_sq;
    assign w_sq = 36'(r_az[17:0]) * 36'(r_az[17:0]);
    always_ff @(posedge i_clk) begin
        r_k3 <= r_k2;
        if (r_k2 == KERNEL_GAUSS) begin
            r_lim  <= '0;
            if (r_az < 48'(8 << 16))
                r_term <= GAUSS_TABLE[GIDX_W'((64'(r_az) * GAUSS_TABLE_DEPTH) >> 19)];
            else
                r_term <= '0;
        end else begin
            r_term <= '0;
            if (r_az < 48'(3 << 16) && 36'(w_sq) < 36'h5_0000_0000)
                r_lim <= 35'h5_0000_0000 - 35'(w_sq);
            else
                r_lim <= '0;
        end
    end

    // stage 4: epanechnikov product, keep the part above 2^32
    logic [58:0] w_ep;
    assign w_ep = 59'(r_lim) * 59'(EPA_Q24);
    always_ff @(posedge i_clk) begin
        r_hi    <= w_ep[58:32];
        r_k4    <= r_k3;
        r_gterm <= r_term;
    end

    // stage 5: floor(x/5) for x < 2^32 via reciprocal
    logic [26:0] w_q;
    assign w_q = 27'((64'(r_hi) * 64'hCCCC_CCCD) >> 34);
    always_ff @(posedge i_clk) begin
        o_term <= r_k4 ? w_q[23:0] : r_gterm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) {r_v1, r_v2, r_v3, r_v4, r_v5} <= '0;
        else begin
            r_v1 <= i_ctl.valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
        end
    end
    assign o_valid = r_v5;
endmodule
`default_nettype wire

// File: design/kde_scale.sv
// kde_scale: density = floor(sum * inv_bw / (count * 2^16)) with saturation
// multi-cycle restoring divider; depends on kde_pkg
`timescale 1ns / 1ps
`default_nettype none
module kde_scale import kde_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_sum,
    input  wire logic [31:0]      i_inv_bw,
    input  wire logic [CNT_W-1:0] i_count,
    output logic                  o_done,
    output logic [31:0]           o_density
);
    localparam int NUM_W = SUM_W + 32;
    localparam int DEN_W = CNT_W + 16;
    localparam int STEP_W = $clog2(NUM_W + 2);
    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [STEP_W-1:0] r_step;
    logic r_busy, r_mul;
    logic [SUM_W-1:0] r_sum;
    logic [31:0] r_bw;

    // one quotient bit per cycle once the registered multiply is done
    logic [DEN_W:0] w_tr;
    assign w_tr = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
        end else if (i_start) begin
            r_sum <= i_sum; r_bw <= i_inv_bw;
            r_den <= {i_count, 16'd0};
            r_mul <= 1'b1;
        end else if (r_mul) begin
            r_num  <= NUM_W'(r_sum) * NUM_W'(r_bw);
            r_rem  <= '0;
            r_step <= STEP_W'(NUM_W);
            r_mul  <= 1'b0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (w_tr >= {1'b0, r_den}) begin
                r_rem <= w_tr - {1'b0, r_den};
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_tr;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
            r_step <= r_step - 1'b1;
            if (r_step == 1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end
    assign o_density = (|r_num[NUM_W-1:32]) ? 32'hFFFF_FFFF : r_num[31:0];
endmodule
`default_nettype wire
